@@ hdl/jlav_pkg.sv @@
// Shared types, widths and zone codes for the joint limit avoidance velocity block.
// Depends on nothing; every other file imports it.
package jlav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 24;
  localparam int REGION_W  = 23;
  localparam int GAIN_W    = 24;
  localparam int MAXV_W    = 23;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_W     = REGION_W;
  localparam int NUM_W     = GAIN_W + FRAC_BITS;
  localparam int SUM_W     = POS_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_AVOID_GAIN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
  localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(65536);

  typedef enum logic [2:0] {
    ZONE_FREE     = 3'd0,
    ZONE_BELOW_LO = 3'd1,
    ZONE_NEAR_LO  = 3'd2,
    ZONE_ABOVE_HI = 3'd3,
    ZONE_NEAR_HI  = 3'd4
  } zone_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] lower_limit;
    logic signed [POS_W-1:0] upper_limit;
    logic [REGION_W-1:0]     region_size;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] avoid_velocity;
    zone_t                   zone;
  } result_t;

  // One division lane: partial remainder and the shared numerator/quotient word.
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DIV_W-1:0] divisor;
  } lane_t;

  typedef struct packed {
    logic  valid;
    zone_t zone;
    logic  dzero;
    lane_t lane_d;
    lane_t lane_r;
  } cell_t;

endpackage

@@ hdl/jlav_front.sv @@
// Input stage: classifies a sample into its zone and loads both divider lanes.
// Depends on jlav_pkg.
module jlav_front import jlav_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              take,
  input  sample_t           sample,
  input  logic [GAIN_W-1:0] avoid_gain,
  output cell_t             stage
);

  logic signed [SUM_W-1:0] q, lo, hi, reg_s;
  logic signed [SUM_W-1:0] d_lo, d_hi, d_sel;
  logic below, near_lo, above, near_hi;
  zone_t zone;

  always_comb begin
    q     = SUM_W'(sample.position);
    lo    = SUM_W'(sample.lower_limit);
    hi    = SUM_W'(sample.upper_limit);
    reg_s = $signed({2'b00, sample.region_size});
    below   = q < lo;
    near_lo = q < (lo + reg_s);
    above   = q > hi;
    near_hi = q > (hi - reg_s);
    d_lo = q - lo;
    d_hi = hi - q;
    // The upper tests take precedence over the lower ones.
    if (above) begin
      zone = ZONE_ABOVE_HI;
    end else if (near_hi) begin
      zone = ZONE_NEAR_HI;
    end else if (below) begin
      zone = ZONE_BELOW_LO;
    end else if (near_lo) begin
      zone = ZONE_NEAR_LO;
    end else begin
      zone = ZONE_FREE;
    end
    d_sel = (zone == ZONE_NEAR_HI) ? d_hi : d_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= take;
    end
    if (en) begin
      stage.zone           <= zone;
      stage.dzero          <= (d_sel == '0);
      stage.lane_d.rem     <= '0;
      stage.lane_d.nq      <= {avoid_gain, {FRAC_BITS{1'b0}}};
      stage.lane_d.divisor <= d_sel[DIV_W-1:0];
      stage.lane_r.rem     <= '0;
      stage.lane_r.nq      <= {avoid_gain, {FRAC_BITS{1'b0}}};
      stage.lane_r.divisor <= sample.region_size;
    end
  end

endmodule

@@ hdl/jlav_div_cell.sv @@
// One restoring-division cell: settles one quotient bit in each of two lanes.
// Depends on jlav_pkg.
module jlav_div_cell import jlav_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t up,
  output cell_t down
);

  function automatic lane_t step(input lane_t l);
    logic [DIV_W:0] trial;
    logic           ge;
    lane_t          o;
    trial = {l.rem, l.nq[NUM_W-1]};
    ge    = trial >= {1'b0, l.divisor};
    o.divisor = l.divisor;
    o.rem     = ge ? DIV_W'(trial - {1'b0, l.divisor}) : trial[DIV_W-1:0];
    o.nq      = {l.nq[NUM_W-2:0], ge};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (en) begin
      down.valid <= up.valid;
    end
    if (en) begin
      down.zone   <= up.zone;
      down.dzero  <= up.dzero;
      down.lane_d <= step(up.lane_d);
      down.lane_r <= step(up.lane_r);
    end
  end

endmodule

@@ hdl/jlav_back.sv @@
// Output stage: takes the two quotients, clamps the difference and signs it by zone.
// Depends on jlav_pkg.
module jlav_back import jlav_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cell_t             last,
  input  logic [MAXV_W-1:0] max_velocity,
  output logic              result_valid,
  output result_t           result
);

  logic [NUM_W-1:0]        diff;
  logic [MAXV_W-1:0]       mag;
  logic signed [POS_W-1:0] pos_max, pos_mag, vel;

  always_comb begin
    // Distance is below the region, so the distance quotient is never the smaller one.
    diff = last.lane_d.nq - last.lane_r.nq;
    if (last.dzero || (diff > NUM_W'(max_velocity))) begin
      mag = max_velocity;
    end else begin
      mag = diff[MAXV_W-1:0];
    end
    pos_max = $signed({1'b0, max_velocity});
    pos_mag = $signed({1'b0, mag});
    case (last.zone)
      ZONE_BELOW_LO: vel = pos_max;
      ZONE_NEAR_LO:  vel = pos_mag;
      ZONE_ABOVE_HI: vel = -pos_max;
      ZONE_NEAR_HI:  vel = -pos_mag;
      default:       vel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last.valid;
    end
    if (en) begin
      result.avoid_velocity <= vel;
      result.zone           <= last.zone;
    end
  end

endmodule

@@ hdl/joint_limit_avoidance_velocity.sv @@
// Joint limit avoidance velocity, top level; uses jlav_pkg, jlav_front,
// jlav_div_cell and jlav_back.
// A sample is registered in the front stage, in each division cell and in the output stage.
// Throughput: one word per cycle while the result is not stalled, one quotient bit per cell.
// Reset (synchronous, rst high) empties the pipeline and restores both registers.
module joint_limit_avoidance_velocity import jlav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers. The user must change them only while no word is in
  // flight; the block does not enforce this. The front and back stages read them directly.
  logic [GAIN_W-1:0] avoid_gain;
  logic [MAXV_W-1:0] max_velocity;

  always_ff @(posedge clk) begin
    if (rst) begin
      avoid_gain   <= GAIN_RESET;
      max_velocity <= MAXV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AVOID_GAIN:   avoid_gain   <= cfg_data[GAIN_W-1:0];
        REG_MAX_VELOCITY: max_velocity <= cfg_data[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole chain moves as one: it advances whenever the output register
  // is empty or its word is being taken this cycle. A stalled result freezes
  // every stage, so nothing is lost and nothing is duplicated.
  logic en;
  assign en           = !result_valid || result_ready;
  assign sample_ready = en;

  // Stage 0 holds the classified sample; stage k holds it after k quotient bits.
  cell_t chain [NUM_W+1];

  jlav_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .take       (sample_valid),
    .sample     (sample),
    .avoid_gain (avoid_gain),
    .stage      (chain[0])
  );

  // Each cell divides gain * 2^FRAC_BITS by the distance in one lane and by
  // the region size in the other, one bit per cell, most significant first.
  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    jlav_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .up   (chain[k]),
      .down (chain[k+1])
    );
  end

  // The last stage subtracts the quotients, clamps to max_velocity, applies
  // the zero-distance saturation and signs the result by zone.
  jlav_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .last         (chain[NUM_W]),
    .max_velocity (max_velocity),
    .result_valid (result_valid),
    .result       (result)
  );

  // A free joint never gets a velocity.
  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.zone == ZONE_FREE) |-> result.avoid_velocity == '0)
    else $error("free zone with nonzero velocity");

  // Near the lower limit the velocity lies in [0, max_velocity].
  a_near_lo_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.zone == ZONE_NEAR_LO) |->
      (result.avoid_velocity >= 0) &&
      (result.avoid_velocity <= $signed({1'b0, max_velocity})))
    else $error("near-lower velocity out of range");

  // Near the upper limit the velocity lies in [-max_velocity, 0].
  a_near_hi_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.zone == ZONE_NEAR_HI) |->
      (result.avoid_velocity <= 0) &&
      (result.avoid_velocity >= -$signed({1'b0, max_velocity})))
    else $error("near-upper velocity out of range");

endmodule

@@ sim/jlav_checker.sv @@
// Scoreboard for the joint limit avoidance velocity block: it mirrors the register
// writes, predicts every accepted sample and compares each accepted result word.
// Depends on jlav_pkg for the word types, widths and zone codes.
module jlav_checker import jlav_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_ready,
  input  sample_t              sample,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   compared
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [GAIN_W-1:0] gain_copy;
  logic [MAXV_W-1:0] maxv_copy;
  result_t           velocity_fifo[$];
  int                mismatch_count;
  int                match_count;

  // Magnitude of the push-back: gain/d - gain/region, truncated quotients,
  // clamped to [0, maxv]. A zero distance saturates to the clamp.
  function automatic longint push_back(longint d, longint region, longint gain,
                                       longint maxv);
    longint num;
    longint r;
    if (d <= 0) return maxv;
    num = gain << FRAC_BITS;
    r = num / d - ((region > 0) ? num / region : 0);
    if (r > maxv) r = maxv;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic result_t predict_avoidance(sample_t s, logic [GAIN_W-1:0] gain,
                                                logic [MAXV_W-1:0] maxv);
    longint  q;
    longint  lo;
    longint  hi;
    longint  region;
    longint  vmax;
    longint  vel;
    result_t r;
    q      = longint'($signed(s.position));
    lo     = longint'($signed(s.lower_limit));
    hi     = longint'($signed(s.upper_limit));
    region = longint'(s.region_size);
    vmax   = longint'(maxv);
    vel    = 0;
    r.zone = ZONE_FREE;
    if (q < lo) begin
      vel    = vmax;
      r.zone = ZONE_BELOW_LO;
    end else if (q < lo + region) begin
      vel    = push_back(q - lo, region, longint'(gain), vmax);
      r.zone = ZONE_NEAR_LO;
    end
    // The upper limit is tested last and wins when both apply.
    if (q > hi) begin
      vel    = -vmax;
      r.zone = ZONE_ABOVE_HI;
    end else if (q > hi - region) begin
      vel    = -push_back(hi - q, region, longint'(gain), vmax);
      r.zone = ZONE_NEAR_HI;
    end
    r.avoid_velocity = vel[POS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gain_copy = GAIN_RESET;
      maxv_copy = MAXV_RESET;
      velocity_fifo.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_AVOID_GAIN) gain_copy = cfg_data[GAIN_W-1:0];
        else if (cfg_index == REG_MAX_VELOCITY) maxv_copy = cfg_data[MAXV_W-1:0];
      end
      // Results are checked before this edge's sample is queued, so a stray
      // result can never be matched against a sample taken at the same edge.
      if (result_valid && result_ready) begin
        if (velocity_fifo.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result word: velocity %0d zone %0d",
                     result.avoid_velocity, result.zone);
        end else begin
          want = velocity_fifo.pop_front();
          if (result.avoid_velocity !== want.avoid_velocity || result.zone !== want.zone)
          begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected velocity %0d zone %0d, got velocity %0d zone %0d",
                       want.avoid_velocity, want.zone, result.avoid_velocity, result.zone);
          end else begin
            match_count++;
          end
        end
      end
      if (sample_valid && sample_ready)
        velocity_fifo.push_back(predict_avoidance(sample, gain_copy, maxv_copy));
    end
    errors   <= mismatch_count;
    pending  <= velocity_fifo.size();
    compared <= match_count;
  end

endmodule

@@ sim/tb_joint_limit_avoidance_velocity.sv @@
// Testbench top for joint_limit_avoidance_velocity: drives samples, result stalls
// and register writes, and gives the verdict from the scoreboard's counts.
// Depends on jlav_pkg, jlav_checker and the block's RTL.
module tb_joint_limit_avoidance_velocity import jlav_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Field extremes in raw fixed point, and 1.0 with 16 fraction bits.
  localparam longint MAXP = 8388607;
  localparam longint MINP = -8388608;
  localparam longint MAXR = 8388607;
  localparam longint ONE  = 65536;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [MAXV_W-1:0] MAXV_MAX = '1;

  // The limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  // This is how long we listen after draining.
  localparam int TAIL_CYCLES = 60;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  sample_t              sample       = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  int errors;
  int pending;
  int compared;
  int cycles       = 0;
  int sent         = 0;
  int settings     = 1;
  int gap_max      = 10;
  bit rx_calm      = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  joint_limit_avoidance_velocity u_top (
    .clk,
    .rst,
    .sample_valid,
    .sample_ready,
    .sample,
    .result_valid,
    .result_ready,
    .result,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  // The scoreboard sits beside the block and only watches its ports.
  jlav_checker u_checker (
    .clk,
    .rst,
    .sample_valid,
    .sample_ready,
    .sample,
    .result_valid,
    .result_ready,
    .result,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .errors,
    .pending,
    .compared
  );

  function automatic longint clip(longint v, longint lo_b, longint hi_b);
    return (v < lo_b) ? lo_b : ((v > hi_b) ? hi_b : v);
  endfunction

  // Builds a joint sample from raw fixed-point values, pinned to the field ranges
  // so that the geometry we intended survives packing.
  function automatic sample_t mk(longint pos, longint lo, longint hi, longint region);
    sample_t s;
    s.position    = POS_W'(clip(pos, MINP, MAXP));
    s.lower_limit = POS_W'(clip(lo, MINP, MAXP));
    s.upper_limit = POS_W'(clip(hi, MINP, MAXP));
    s.region_size = REGION_W'(clip(region, 0, MAXR));
    return s;
  endfunction

  // Random joint sample. Most are well formed: a pair of limits with a warning
  // region, and a position placed on a limit, inside a region, just outside a
  // limit, in the free span or anywhere. The rest are raw bit patterns, which
  // also make every bit of every field toggle.
  function automatic sample_t rand_sample();
    sample_t s;
    longint  lo;
    longint  span;
    longint  region;
    longint  off;
    longint  pos;
    if ($urandom_range(9) < 3) begin
      s.position    = POS_W'($urandom());
      s.lower_limit = POS_W'($urandom());
      s.upper_limit = POS_W'($urandom());
      s.region_size = REGION_W'($urandom());
      return s;
    end
    case ($urandom_range(3))
      0:       region = $urandom_range(16);
      1:       region = $urandom_range(4096);
      2:       region = $urandom_range(1 << 18);
      default: region = $urandom_range(MAXR);
    endcase
    lo = longint'($urandom_range(24'hFFFFFF)) + MINP;
    case ($urandom_range(3))
      0:       span = $urandom_range(2 * region + 16);  // regions may overlap
      1:       span = $urandom_range(1 << 20);
      2:       span = $urandom_range(24'hFFFFFF);
      default: span = -longint'($urandom_range(1 << 16));  // crossed limits
    endcase
    off = (region > 0) ? longint'($urandom_range(region - 1)) : 0;
    case ($urandom_range(7))
      0:       pos = lo - 1 - $urandom_range(1 << 16);
      1:       pos = lo;
      2:       pos = lo + off;
      3:       pos = lo + span;
      4:       pos = lo + span - off;
      5:       pos = lo + span + 1 + $urandom_range(1 << 16);
      6:       pos = lo + region + $urandom_range(1 << 12);
      default: pos = longint'($urandom_range(24'hFFFFFF)) + MINP;
    endcase
    return mk(pos, lo, lo + span, region);
  endfunction

  // Offers one word and returns at the falling edge after it was taken. Valid
  // stays high into the next word when no gap is drawn.
  task automatic send_sample(sample_t s);
    int gap;
    gap = $urandom_range(gap_max);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       = s;
    sample_valid = 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted word has come back, which
  // leaves the pipeline empty and safe for register writes.
  task automatic drain();
    sample_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(logic [GAIN_W-1:0] gain, logic [MAXV_W-1:0] maxv);
    cfg_we    = 1'b1;
    cfg_index = REG_AVOID_GAIN;
    cfg_data  = CFG_W'(gain);
    @(negedge clk);
    cfg_index = REG_MAX_VELOCITY;
    cfg_data  = CFG_W'(maxv);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // One register setting followed by a burst of random samples. A calm phase
  // has no idling on either side; a squeeze phase sends back to back while the
  // receiver holds off, so the pipeline fills and backpressures the input.
  task automatic run_phase(logic [GAIN_W-1:0] gain, logic [MAXV_W-1:0] maxv, int count,
                           bit calm, bit squeeze);
    drain();
    set_config(gain, maxv);
    settings++;
    gap_max      = (calm || squeeze) ? 0 : 10;
    rx_calm      = calm;
    hold_request = squeeze;
    repeat (count) send_sample(rand_sample());
    gap_max = 10;
    rx_calm = 1'b0;
  endtask

  // Result side: a random stall before each word outside calm phases, plus one
  // long hold-off counted here whenever the stimulus asks for it.
  initial begin : receiver
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = rx_calm ? 0 : $urandom_range(10);
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed samples under the reset registers (gain 1.0, clamp 1.0).
    send_sample(mk(0, -10 * ONE, 10 * ONE, ONE));                  // free joint
    send_sample(mk(-20 * ONE, -10 * ONE, 10 * ONE, ONE));          // below the lower limit
    send_sample(mk(-10 * ONE, -10 * ONE, 10 * ONE, ONE));          // on the lower limit
    send_sample(mk(-10 * ONE + 1, -10 * ONE, 10 * ONE, 2 * ONE));  // tiny distance, clamps
    send_sample(mk(-10 * ONE + ONE / 2, -10 * ONE, 10 * ONE, ONE));
    send_sample(mk(-10 * ONE + 3 * ONE / 4, -10 * ONE, 10 * ONE, ONE));
    send_sample(mk(20 * ONE, -10 * ONE, 10 * ONE, ONE));           // above the upper limit
    send_sample(mk(10 * ONE, -10 * ONE, 10 * ONE, ONE));           // on the upper limit
    send_sample(mk(10 * ONE - ONE / 4, -10 * ONE, 10 * ONE, ONE));
    send_sample(mk(10 * ONE - 3 * ONE / 4, -10 * ONE, 10 * ONE, ONE));
    // A zero-width warning region is never entered, even on a limit.
    send_sample(mk(-10 * ONE, -10 * ONE, 10 * ONE, 0));
    send_sample(mk(10 * ONE, -10 * ONE, 10 * ONE, 0));
    // Crossed limits: both tests fire and the upper one wins.
    send_sample(mk(0, 5 * ONE, -5 * ONE, ONE));
    send_sample(mk(0, 0, 0, ONE));
    // Extremes of every field.
    send_sample(mk(MAXP, MINP, MAXP, MAXR));
    send_sample(mk(MINP, MINP, MAXP, MAXR));
    send_sample(mk(MINP, MAXP, MINP, 0));
    send_sample(mk(MAXP, MAXP, MAXP, MAXR));
    send_sample(mk(0, 0, 0, 0));
    send_sample(mk(MINP, MAXP, MAXP, MAXR));
    send_sample(mk(-1, MINP, 0, MAXR));
    send_sample(mk(MAXP, MINP, MAXP - 1, 1));

    // Register settings, extremes first, then random ones.
    run_phase('0, MAXV_MAX, 100, 1'b0, 1'b0);
    run_phase(GAIN_MAX, MAXV_MAX, 250, 1'b0, 1'b0);
    run_phase(GAIN_MAX, '0, 100, 1'b0, 1'b0);
    run_phase(GAIN_W'(4 * ONE), MAXV_W'(8 * ONE), 250, 1'b0, 1'b1);
    run_phase(GAIN_W'(1), MAXV_W'(1), 100, 1'b0, 1'b0);
    run_phase(GAIN_W'($urandom()), MAXV_W'($urandom()), 250, 1'b1, 1'b0);
    run_phase(GAIN_W'($urandom()), MAXV_W'($urandom()), 280, 1'b0, 1'b0);

    drain();
    // Any word that shows up now has no prediction and counts as an error.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples over %0d register settings, %0d results matched.",
             sent, settings, compared);
    $display("Included gain and clamp extremes, back-to-back traffic and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
